// ----- design/fcgi_nv_pkg.sv -----
// shared types and constants for the fastcgi name-value parser
package fcgi_nv_pkg;

  localparam int unsigned LENGTH_WIDTH_DEF = 31;
  localparam logic [7:0]  SHORT_LIMIT_RESET = 8'd127;

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_PAIR  = 3'd2,
    KIND_OK    = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_NLEN      = 3'd0,
    PH_NLEN_LONG = 3'd1,
    PH_VLEN      = 3'd2,
    PH_VLEN_LONG = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_e;

  // results caused by one input byte, in emission order
  typedef struct packed {
    logic       has_data;
    logic       data_is_value;
    logic [7:0] data_byte;
    logic       has_pair;
    logic       has_end;
    logic       end_ok;
  } bundle_t;

endpackage

// ----- design/fcgi_nv_decoder.sv -----
// length decoding and pair tracking state, one input byte per accept
module fcgi_nv_decoder #(
  parameter int unsigned LENGTH_WIDTH = fcgi_nv_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  accept_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  eoc_i,
  output fcgi_nv_pkg::bundle_t  bundle_o
);

  localparam int unsigned LW = LENGTH_WIDTH;

  logic [7:0]              limit_q;
  fcgi_nv_pkg::phase_e     phase_q, phase_d;
  logic [1:0]              idx_q, idx_d;
  logic [LW-1:0]           nlen_q, nlen_d;
  logic [LW-1:0]           vlen_q, vlen_d;
  logic [LW-1:0]           rem_q, rem_d;
  logic [LW-1:0]           acc_q, acc_d;
  logic                    sticky_q, sticky_d;

  logic [LW+7:0]           shifted;
  logic [LW-1:0]           acc_shift;
  logic                    ovf_shift;
  logic [LW-1:0]           long_final;
  logic [LW-1:0]           rem_dec;
  logic [1:0]              idx_inc;
  logic                    lengths_done;
  logic                    start_value;
  logic                    pair_done;
  fcgi_nv_pkg::bundle_t    bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= fcgi_nv_pkg::SHORT_LIMIT_RESET;
      phase_q  <= fcgi_nv_pkg::PH_NLEN;
      idx_q    <= 2'd0;
      nlen_q   <= '0;
      vlen_q   <= '0;
      rem_q    <= '0;
      acc_q    <= '0;
      sticky_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept_i) begin
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        nlen_q   <= nlen_d;
        vlen_q   <= vlen_d;
        rem_q    <= rem_d;
        acc_q    <= acc_d;
        sticky_q <= sticky_d;
      end
    end
  end

  always_comb begin
    shifted    = {acc_q, in_byte_i};
    acc_shift  = shifted[LW-1:0];
    ovf_shift  = sticky_q | (|shifted[LW+7:LW]);
    long_final = ovf_shift ? '1 : acc_shift;
    rem_dec    = rem_q - LW'(1);
    idx_inc    = idx_q + 2'd1;

    phase_d  = phase_q;
    idx_d    = idx_q;
    nlen_d   = nlen_q;
    vlen_d   = vlen_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    sticky_d = sticky_q;
    bundle   = '0;
    lengths_done = 1'b0;
    start_value  = 1'b0;
    pair_done    = 1'b0;

    unique case (phase_q)
      fcgi_nv_pkg::PH_NLEN, fcgi_nv_pkg::PH_VLEN: begin
        if (in_byte_i <= limit_q) begin
          if (phase_q == fcgi_nv_pkg::PH_NLEN) begin
            nlen_d  = LW'(in_byte_i);
            phase_d = fcgi_nv_pkg::PH_VLEN;
          end else begin
            vlen_d       = LW'(in_byte_i);
            lengths_done = 1'b1;
          end
        end else begin
          acc_d    = LW'({1'b0, in_byte_i[6:0]});
          sticky_d = 1'b0;
          idx_d    = 2'd1;
          phase_d  = (phase_q == fcgi_nv_pkg::PH_NLEN) ? fcgi_nv_pkg::PH_NLEN_LONG
                                                      : fcgi_nv_pkg::PH_VLEN_LONG;
        end
      end
      fcgi_nv_pkg::PH_NLEN_LONG, fcgi_nv_pkg::PH_VLEN_LONG: begin
        acc_d    = acc_shift;
        sticky_d = ovf_shift;
        idx_d    = idx_inc;
        if (idx_inc == 2'd0) begin
          if (phase_q == fcgi_nv_pkg::PH_NLEN_LONG) begin
            nlen_d  = long_final;
            phase_d = fcgi_nv_pkg::PH_VLEN;
          end else begin
            vlen_d       = long_final;
            lengths_done = 1'b1;
          end
        end
      end
      fcgi_nv_pkg::PH_NAME: begin
        bundle.has_data  = 1'b1;
        bundle.data_byte = in_byte_i;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          start_value = 1'b1;
        end
      end
      fcgi_nv_pkg::PH_VALUE: begin
        bundle.has_data      = 1'b1;
        bundle.data_is_value = 1'b1;
        bundle.data_byte     = in_byte_i;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          pair_done = 1'b1;
        end
      end
      default: begin
        phase_d = fcgi_nv_pkg::PH_NLEN;
      end
    endcase

    if (lengths_done) begin
      if (nlen_d != '0) begin
        rem_d   = nlen_d;
        phase_d = fcgi_nv_pkg::PH_NAME;
      end else begin
        start_value = 1'b1;
      end
    end

    if (start_value) begin
      if (vlen_d != '0) begin
        rem_d   = vlen_d;
        phase_d = fcgi_nv_pkg::PH_VALUE;
      end else begin
        pair_done = 1'b1;
      end
    end

    if (pair_done) begin
      bundle.has_pair = 1'b1;
      phase_d = fcgi_nv_pkg::PH_NLEN;
    end

    if (eoc_i) begin
      bundle.has_end = 1'b1;
      bundle.end_ok  = (phase_d == fcgi_nv_pkg::PH_NLEN);
      phase_d = fcgi_nv_pkg::PH_NLEN;
      idx_d   = 2'd0;
      rem_d   = '0;
    end
  end

  assign bundle_o = bundle;

endmodule

// ----- design/fastcgi_name_value_parser_unit.sv -----
// top level of the fastcgi name-value parser: decoder plus result queue
// Parses a FastCGI params body one byte per transfer. Each byte updates the
// decoder state in the cycle it is taken and yields zero to three results
// (data byte, pair complete, content ok or error), which leave one per cycle,
// unless the output stalls, through a two-deep result queue. Bytes causing at
// most one result flow at that rate; one causing two or three holds the single
// output channel until all have left, and the input stalls once the pending
// slot of the queue is full. The length limit register is written over the
// cfg channel, which is always ready; write it only while the block is idle.
module fastcgi_name_value_parser_unit #(
  parameter int unsigned LENGTH_WIDTH = fcgi_nv_pkg::LENGTH_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_content_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] kind_o,
  output logic       last_of_run_o
);

  fcgi_nv_pkg::bundle_t out_q, out_d;
  fcgi_nv_pkg::bundle_t pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  fcgi_nv_pkg::bundle_t new_bundle;
  fcgi_nv_pkg::bundle_t out_rem;
  logic                 accept;
  logic                 new_any;
  logic                 out_xfer;
  logic                 out_last;
  logic                 out_free;
  fcgi_nv_pkg::kind_e   kind;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = pend_valid_q;
  assign accept      = in_valid_i & ~pend_valid_q;

  fcgi_nv_decoder #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .eoc_i      (end_of_content_i),
    .bundle_o   (new_bundle)
  );

  assign new_any     = new_bundle.has_data | new_bundle.has_pair | new_bundle.has_end;
  assign out_valid_o = out_q.has_data | out_q.has_pair | out_q.has_end;
  assign out_xfer    = out_valid_o & ~out_stall_i;

  // current result is the first flag still set
  always_comb begin
    out_rem    = out_q;
    out_byte_o = 8'd0;
    kind       = fcgi_nv_pkg::KIND_OK;
    out_last   = 1'b1;
    if (out_q.has_data) begin
      out_byte_o       = out_q.data_byte;
      kind             = out_q.data_is_value ? fcgi_nv_pkg::KIND_VALUE
                                             : fcgi_nv_pkg::KIND_NAME;
      out_last         = ~(out_q.has_pair | out_q.has_end);
      out_rem.has_data = 1'b0;
    end else if (out_q.has_pair) begin
      kind             = fcgi_nv_pkg::KIND_PAIR;
      out_last         = ~out_q.has_end;
      out_rem.has_pair = 1'b0;
    end else if (out_q.has_end) begin
      kind            = out_q.end_ok ? fcgi_nv_pkg::KIND_OK : fcgi_nv_pkg::KIND_ERROR;
      out_rem.has_end = 1'b0;
    end
  end

  assign kind_o        = kind;
  assign last_of_run_o = out_last;
  assign out_free      = ~out_valid_o | (out_xfer & out_last);

  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end else if (accept && new_any) begin
        out_d = new_bundle;
      end else begin
        out_d = '0;
      end
    end else begin
      if (out_xfer) begin
        out_d = out_rem;
      end
      if (accept && new_any) begin
        pend_d       = new_bundle;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      out_q        <= out_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule
